FILE: sv/ffh_pkg.sv
// Shared constants, codes and controller/datapath interface types of the heap manager.
package ffh_pkg;

   localparam int NUM_VARS   = 16;
   localparam int FREE_SLOTS = 32;
   localparam int ADDR_BITS  = 16;

   localparam int VAR_AW = $clog2(NUM_VARS);
   localparam int FS_AW  = $clog2(FREE_SLOTS);
   localparam int FS_CW  = $clog2(FREE_SLOTS + 1);
   localparam int REF_W  = 5;

   localparam logic [ADDR_BITS-1:0] HEAP_RESET = ADDR_BITS'(4096);
   localparam logic [REF_W-1:0]     REF_MAX    = '1;

   localparam logic [2:0] STAT_OK         = 3'd0;
   localparam logic [2:0] STAT_NO_FIT     = 3'd1;
   localparam logic [2:0] STAT_UNKNOWN    = 3'd2;
   localparam logic [2:0] STAT_BAD_SHRINK = 3'd3;
   localparam logic [2:0] STAT_LIST_FULL  = 3'd4;

   typedef logic [ADDR_BITS-1:0] addr_type;

   typedef enum logic [1:0] {
      OP_ALLOC    = 2'd0,
      OP_ALIAS    = 2'd1,
      OP_FREE     = 2'd2,
      OP_COMPRESS = 2'd3
   } opcode_type;

   typedef struct packed {
      addr_type addr;
      addr_type size;
   } free_entry_type;

   typedef enum logic [1:0] {
      RD_I     = 2'd0,
      RD_J_DEC = 2'd1,
      RD_J_INC = 2'd2,
      RD_ZERO  = 2'd3
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_NEW  = 2'd0,
      WR_MOVE = 2'd1,
      WR_TAKE = 2'd2,
      WR_CUR  = 2'd3
   } wr_sel_type;

   typedef struct packed {
      logic       load_req;
      logic       rd_src;
      logic       status_we;
      logic [2:0] status_code;
      logic       shrink;
      logic       do_alias;
      logic       do_free;
      logic       set_key;
      logic       take;
      logic       clr_cnt;
      logic       inc_i;
      logic       inc_j;
      logic       dec_j;
      logic       j_from_fc;
      logic       j_from_i;
      rd_sel_type rd_sel;
      logic       mem_we;
      wr_sel_type wr_sel;
      logic       fc_inc;
      logic       fc_dec;
      logic       fc_set_wnext;
      logic       cur_load;
      logic       cur_merge;
      logic       rsp_load;
      logic       init;
   } ctrl_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       vok;
      logic       sok;
      logic       ent_valid;
      logic       n_gt_size;
      logic       tail_zero;
      logic       list_full;
      logic       same_vs;
      logic       give_nonempty;
      logic       i_end;
      logic       ins_hit;
      logic       fit;
      logic       take_empty;
      logic       j_at_i;
      logic       rem_end;
      logic       adjacent;
      logic       fc_zero;
   } dp_stat_type;

endpackage

FILE: sv/ffh_ctrl.sv
// Controller state machine that sequences every heap operation over the datapath.
module ffh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ffh_pkg::dp_stat_type stat,
   output ffh_pkg::ctrl_cmd_type cmd
);

   typedef enum logic [15:0] {
      S_INIT      = 16'h0001,
      S_IDLE      = 16'h0002,
      S_DECODE    = 16'h0004,
      S_ASCAN_RD  = 16'h0008,
      S_ASCAN_CHK = 16'h0010,
      S_REM_RD    = 16'h0020,
      S_REM_WR    = 16'h0040,
      S_INS_RD    = 16'h0080,
      S_INS_CHK   = 16'h0100,
      S_SHIFT     = 16'h0200,
      S_SHIFT_WR  = 16'h0400,
      S_CMP_LD    = 16'h0800,
      S_CMP_NXT   = 16'h1000,
      S_CMP_CHK   = 16'h2000,
      S_CMP_WR    = 16'h4000,
      S_FINISH    = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.rd_sel = ffh_pkg::RD_I;
      cmd.wr_sel = ffh_pkg::WR_NEW;
      case (state_ff)
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.rd_src = (stat.op == ffh_pkg::OP_ALIAS);
            state_in = S_FINISH;
            case (stat.op)
               ffh_pkg::OP_ALLOC: begin
                  if (!stat.vok) begin
                     cmd.status_we = 1'b1;
                     cmd.status_code = ffh_pkg::STAT_UNKNOWN;
                  end else if (!stat.ent_valid) begin
                     cmd.clr_cnt = 1'b1;
                     state_in = S_ASCAN_RD;
                  end else if (stat.n_gt_size) begin
                     cmd.status_we = 1'b1;
                     cmd.status_code = ffh_pkg::STAT_BAD_SHRINK;
                  end else if (stat.tail_zero) begin
                     state_in = S_FINISH;
                  end else if (stat.list_full) begin
                     cmd.status_we = 1'b1;
                     cmd.status_code = ffh_pkg::STAT_LIST_FULL;
                  end else begin
                     cmd.shrink = 1'b1;
                     cmd.set_key = 1'b1;
                     cmd.clr_cnt = 1'b1;
                     state_in = S_INS_RD;
                  end
               end
               ffh_pkg::OP_ALIAS: begin
                  if (!stat.vok || !stat.sok || !stat.ent_valid) begin
                     cmd.status_we = 1'b1;
                     cmd.status_code = ffh_pkg::STAT_UNKNOWN;
                  end else if (!stat.same_vs) begin
                     cmd.do_alias = 1'b1;
                  end
               end
               ffh_pkg::OP_FREE: begin
                  if (!stat.vok || !stat.ent_valid) begin
                     cmd.status_we = 1'b1;
                     cmd.status_code = ffh_pkg::STAT_UNKNOWN;
                  end else if (stat.give_nonempty && stat.list_full) begin
                     cmd.status_we = 1'b1;
                     cmd.status_code = ffh_pkg::STAT_LIST_FULL;
                  end else begin
                     cmd.do_free = 1'b1;
                     if (stat.give_nonempty) begin
                        cmd.set_key = 1'b1;
                        cmd.clr_cnt = 1'b1;
                        state_in = S_INS_RD;
                     end
                  end
               end
               default: begin
                  cmd.clr_cnt = 1'b1;
                  if (!stat.fc_zero) begin
                     cmd.rd_sel = ffh_pkg::RD_ZERO;
                     state_in = S_CMP_LD;
                  end
               end
            endcase
         end
         S_ASCAN_RD: begin
            if (stat.i_end) begin
               cmd.status_we = 1'b1;
               cmd.status_code = ffh_pkg::STAT_NO_FIT;
               state_in = S_FINISH;
            end else begin
               cmd.rd_sel = ffh_pkg::RD_I;
               state_in = S_ASCAN_CHK;
            end
         end
         S_ASCAN_CHK: begin
            if (stat.fit) begin
               cmd.take = 1'b1;
               if (stat.take_empty) begin
                  cmd.j_from_i = 1'b1;
                  state_in = S_REM_RD;
               end else begin
                  cmd.mem_we = 1'b1;
                  cmd.wr_sel = ffh_pkg::WR_TAKE;
                  state_in = S_FINISH;
               end
            end else begin
               cmd.inc_i = 1'b1;
               state_in = S_ASCAN_RD;
            end
         end
         S_REM_RD: begin
            if (stat.rem_end) begin
               cmd.fc_dec = 1'b1;
               state_in = S_FINISH;
            end else begin
               cmd.rd_sel = ffh_pkg::RD_J_INC;
               state_in = S_REM_WR;
            end
         end
         S_REM_WR: begin
            cmd.mem_we = 1'b1;
            cmd.wr_sel = ffh_pkg::WR_MOVE;
            cmd.inc_j = 1'b1;
            state_in = S_REM_RD;
         end
         S_INS_RD: begin
            if (stat.i_end) begin
               cmd.j_from_fc = 1'b1;
               state_in = S_SHIFT;
            end else begin
               cmd.rd_sel = ffh_pkg::RD_I;
               state_in = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            if (stat.ins_hit) begin
               cmd.j_from_fc = 1'b1;
               state_in = S_SHIFT;
            end else begin
               cmd.inc_i = 1'b1;
               state_in = S_INS_RD;
            end
         end
         S_SHIFT: begin
            if (stat.j_at_i) begin
               cmd.mem_we = 1'b1;
               cmd.wr_sel = ffh_pkg::WR_NEW;
               cmd.fc_inc = 1'b1;
               state_in = S_FINISH;
            end else begin
               cmd.rd_sel = ffh_pkg::RD_J_DEC;
               state_in = S_SHIFT_WR;
            end
         end
         S_SHIFT_WR: begin
            cmd.mem_we = 1'b1;
            cmd.wr_sel = ffh_pkg::WR_MOVE;
            cmd.dec_j = 1'b1;
            state_in = S_SHIFT;
         end
         S_CMP_LD: begin
            cmd.cur_load = 1'b1;
            cmd.inc_i = 1'b1;
            state_in = S_CMP_NXT;
         end
         S_CMP_NXT: begin
            if (stat.i_end) begin
               state_in = S_CMP_WR;
            end else begin
               cmd.rd_sel = ffh_pkg::RD_I;
               state_in = S_CMP_CHK;
            end
         end
         S_CMP_CHK: begin
            cmd.inc_i = 1'b1;
            if (stat.adjacent) begin
               cmd.cur_merge = 1'b1;
            end else begin
               cmd.mem_we = 1'b1;
               cmd.wr_sel = ffh_pkg::WR_CUR;
               cmd.inc_j = 1'b1;
               cmd.cur_load = 1'b1;
            end
            state_in = S_CMP_NXT;
         end
         S_CMP_WR: begin
            cmd.mem_we = 1'b1;
            cmd.wr_sel = ffh_pkg::WR_CUR;
            cmd.fc_set_wnext = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DECODE))
      else $error("accepted request did not move to decode");
   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished request not presented");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("pending result dropped before it was taken");
`endif

endmodule

FILE: sv/ffh_datapath.sv
// Datapath: variable table, free-list memory, scan counters and result register.
module ffh_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ffh_pkg::ctrl_cmd_type cmd,
   output ffh_pkg::dp_stat_type  stat,
   input  logic [1:0]            req_opcode,
   input  logic [3:0]            req_var_id,
   input  logic [3:0]            req_src_var,
   input  logic [15:0]           req_alloc_size,
   input  logic                  csr_we,
   input  logic [15:0]           csr_heap_size,
   output logic [2:0]            rsp_status,
   output logic [15:0]           rsp_block_addr,
   output logic [15:0]           rsp_block_size,
   output logic [4:0]            rsp_ref_count
);

   localparam int AB = ffh_pkg::ADDR_BITS;
   localparam int CW = ffh_pkg::FS_CW;
   localparam int RW = ffh_pkg::REF_W;

   // Variable table.
   logic                     vt_valid_ff [ffh_pkg::NUM_VARS];
   ffh_pkg::addr_type        vt_addr_ff  [ffh_pkg::NUM_VARS];
   ffh_pkg::addr_type        vt_size_ff  [ffh_pkg::NUM_VARS];
   logic [RW-1:0]            vt_refs_ff  [ffh_pkg::NUM_VARS];

   // Free-list memory.
   ffh_pkg::free_entry_type  fl_mem [ffh_pkg::FREE_SLOTS];
   ffh_pkg::free_entry_type  rdata_ff;
   logic [ffh_pkg::FS_AW-1:0] raddr, waddr;
   ffh_pkg::free_entry_type  wdata;

   ffh_pkg::opcode_type      op_ff;
   logic [3:0]               v_ff, s_ff;
   logic [15:0]              n_ff;
   logic [2:0]               status_ff;
   logic [CW-1:0]            fc_ff, fc_in, i_ff, i_in, j_ff, j_in;
   logic [AB:0]              key_ff;
   ffh_pkg::addr_type        ins_size_ff;
   ffh_pkg::free_entry_type  cur_ff;
   logic [2:0]               rsp_status_ff;
   logic [15:0]              rsp_addr_ff, rsp_size_ff;
   logic [RW-1:0]            rsp_refs_ff;

   logic [ffh_pkg::VAR_AW-1:0] vidx, sidx, ridx;
   logic                     rd_ok, ent_valid;
   ffh_pkg::addr_type        ent_addr, ent_size, n_ext;
   logic [RW-1:0]            ent_refs, sat_refs;
   logic [AB:0]              cur_end, merge_sum;
   logic [CW:0]              j_next;

   assign vidx = ffh_pkg::VAR_AW'(v_ff);
   assign sidx = ffh_pkg::VAR_AW'(s_ff);
   assign ridx = cmd.rd_src ? sidx : vidx;
   assign rd_ok = cmd.rd_src ? (32'(s_ff) < ffh_pkg::NUM_VARS) : (32'(v_ff) < ffh_pkg::NUM_VARS);
   assign ent_valid = rd_ok && vt_valid_ff[ridx];
   assign ent_addr = vt_addr_ff[ridx];
   assign ent_size = vt_size_ff[ridx];
   assign ent_refs = vt_refs_ff[ridx];
   assign n_ext = AB'(n_ff);
   assign sat_refs = (ent_refs == ffh_pkg::REF_MAX) ? ent_refs : ent_refs + 1'b1;
   assign cur_end = {1'b0, cur_ff.addr} + {1'b0, cur_ff.size};
   assign merge_sum = {1'b0, cur_ff.size} + {1'b0, rdata_ff.size};
   assign j_next = {1'b0, j_ff} + 1'b1;

   always_comb begin
      stat.op = op_ff;
      stat.vok = (32'(v_ff) < ffh_pkg::NUM_VARS);
      stat.sok = (32'(s_ff) < ffh_pkg::NUM_VARS);
      stat.ent_valid = ent_valid;
      stat.n_gt_size = n_ext > ent_size;
      stat.tail_zero = (ent_size == n_ext);
      stat.list_full = (fc_ff >= CW'(ffh_pkg::FREE_SLOTS));
      stat.same_vs = (v_ff == s_ff);
      stat.give_nonempty = (ent_refs <= RW'(1)) && (ent_size != '0);
      stat.i_end = (i_ff == fc_ff);
      stat.ins_hit = ({1'b0, rdata_ff.addr} > key_ff);
      stat.fit = (rdata_ff.size >= n_ext);
      stat.take_empty = (rdata_ff.size == n_ext);
      stat.j_at_i = (j_ff == i_ff);
      stat.rem_end = (j_next >= {1'b0, fc_ff});
      stat.adjacent = (cur_end == {1'b0, rdata_ff.addr});
      stat.fc_zero = (fc_ff == '0);
   end

   // Memory addressing.
   always_comb begin
      case (cmd.rd_sel)
         ffh_pkg::RD_I:     raddr = i_ff[ffh_pkg::FS_AW-1:0];
         ffh_pkg::RD_J_DEC: raddr = ffh_pkg::FS_AW'(j_ff - 1'b1);
         ffh_pkg::RD_J_INC: raddr = j_next[ffh_pkg::FS_AW-1:0];
         default:           raddr = '0;
      endcase
      waddr = (cmd.wr_sel == ffh_pkg::WR_TAKE) ? i_ff[ffh_pkg::FS_AW-1:0]
                                               : j_ff[ffh_pkg::FS_AW-1:0];
      case (cmd.wr_sel)
         ffh_pkg::WR_NEW: wdata = '{addr: key_ff[AB-1:0], size: ins_size_ff};
         ffh_pkg::WR_MOVE: wdata = rdata_ff;
         ffh_pkg::WR_TAKE: wdata = '{addr: rdata_ff.addr + n_ext,
                                     size: rdata_ff.size - n_ext};
         default: wdata = cur_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (csr_we) begin
         fl_mem[0] <= '{addr: '0, size: AB'(csr_heap_size)};
      end else if (cmd.init) begin
         fl_mem[0] <= '{addr: '0, size: ffh_pkg::HEAP_RESET};
      end else if (cmd.mem_we) begin
         fl_mem[waddr] <= wdata;
      end
      rdata_ff <= fl_mem[raddr];
   end

   // Counters and free count.
   always_comb begin
      fc_in = fc_ff;
      if (csr_we) begin
         fc_in = (csr_heap_size != '0) ? CW'(1) : '0;
      end else if (cmd.init) begin
         fc_in = CW'(1);
      end else if (cmd.fc_inc) begin
         fc_in = fc_ff + 1'b1;
      end else if (cmd.fc_dec) begin
         fc_in = fc_ff - 1'b1;
      end else if (cmd.fc_set_wnext) begin
         fc_in = j_next[CW-1:0];
      end
      i_in = i_ff;
      if (cmd.clr_cnt) begin
         i_in = '0;
      end else if (cmd.inc_i) begin
         i_in = i_ff + 1'b1;
      end
      j_in = j_ff;
      if (cmd.clr_cnt) begin
         j_in = '0;
      end else if (cmd.j_from_fc) begin
         j_in = fc_ff;
      end else if (cmd.j_from_i) begin
         j_in = i_ff;
      end else if (cmd.inc_j) begin
         j_in = j_next[CW-1:0];
      end else if (cmd.dec_j) begin
         j_in = j_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= CW'(1);
         i_ff <= '0;
         j_ff <= '0;
         status_ff <= ffh_pkg::STAT_OK;
      end else begin
         fc_ff <= fc_in;
         i_ff <= i_in;
         j_ff <= j_in;
         if (cmd.load_req) begin
            status_ff <= ffh_pkg::STAT_OK;
         end else if (cmd.status_we) begin
            status_ff <= cmd.status_code;
         end
      end
   end

   // Request latch, insert key and compress accumulator.
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= ffh_pkg::opcode_type'(req_opcode);
         v_ff <= req_var_id;
         s_ff <= req_src_var;
         n_ff <= req_alloc_size;
      end
      if (cmd.set_key) begin
         if (op_ff == ffh_pkg::OP_ALLOC) begin
            key_ff <= {1'b0, ent_addr} + {1'b0, n_ext};
            ins_size_ff <= ent_size - n_ext;
         end else begin
            key_ff <= {1'b0, ent_addr};
            ins_size_ff <= ent_size;
         end
      end
      if (cmd.cur_load) begin
         cur_ff <= rdata_ff;
      end else if (cmd.cur_merge) begin
         cur_ff.size <= merge_sum[AB] ? '1 : merge_sum[AB-1:0];
      end
   end

   // Variable table updates.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ffh_pkg::NUM_VARS; k++) begin
            vt_valid_ff[k] <= 1'b0;
         end
      end else begin
         if (cmd.shrink) begin
            vt_size_ff[vidx] <= n_ext;
         end
         if (cmd.do_alias) begin
            vt_refs_ff[sidx] <= sat_refs;
            vt_valid_ff[vidx] <= 1'b1;
            vt_addr_ff[vidx] <= ent_addr;
            vt_size_ff[vidx] <= ent_size;
            vt_refs_ff[vidx] <= sat_refs;
         end
         if (cmd.do_free) begin
            for (int k = 0; k < ffh_pkg::NUM_VARS; k++) begin
               if (ffh_pkg::VAR_AW'(k) != vidx && vt_valid_ff[k] &&
                   vt_addr_ff[k] == ent_addr && vt_refs_ff[k] != '0) begin
                  vt_refs_ff[k] <= vt_refs_ff[k] - 1'b1;
               end
            end
            vt_valid_ff[vidx] <= 1'b0;
         end
         if (cmd.take) begin
            vt_valid_ff[vidx] <= 1'b1;
            vt_addr_ff[vidx] <= rdata_ff.addr;
            vt_size_ff[vidx] <= n_ext;
            vt_refs_ff[vidx] <= RW'(1);
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_addr_ff <= ent_valid ? 16'(ent_addr) : '0;
         rsp_size_ff <= ent_valid ? 16'(ent_size) : '0;
         rsp_refs_ff <= ent_valid ? ent_refs : '0;
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_block_addr = rsp_addr_ff;
   assign rsp_block_size = rsp_size_ff;
   assign rsp_ref_count = rsp_refs_ff;

`ifndef SYNTHESIS
   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= CW'(ffh_pkg::FREE_SLOTS))
      else $error("free count beyond slot count");
   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      cmd.fc_inc |-> (fc_ff < CW'(ffh_pkg::FREE_SLOTS)))
      else $error("insert into a full free list");
   a_no_remove_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.fc_dec |-> (fc_ff != '0))
      else $error("removal from an empty free list");
`endif

endmodule

FILE: sv/first_fit_heap_with_aliases.sv
// Top level of the first-fit heap manager: controller plus datapath.
// Alias, free without return and requests refused at decode go from decode straight to the
// finish state, which loads the result register once the previous result has been taken.
// Scans read the free list entry by entry; an insert or removal moves the later entries one
// at a time, and compress walks every entry and writes the merged blocks back from the start.
// One request is in work at a time; the next is taken while the result waits to be taken.
// Reset is synchronous: after reset the init state rebuilds the free list as one 4096 block.
module first_fit_heap_with_aliases (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_var_id,
   input  logic [3:0]  req_src_var,
   input  logic [15:0] req_alloc_size,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_block_addr,
   output logic [15:0] rsp_block_size,
   output logic [4:0]  rsp_ref_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_heap_size
);

   ffh_pkg::ctrl_cmd_type cmd;
   ffh_pkg::dp_stat_type  stat;

   // Heap size writes are taken at any time; the user must send them only while idle (the
   // block does not enforce it); they rebuild the free list as one block at address zero.
   assign csr_ready = 1'b1;

   // The controller walks each request through its steps; the datapath holds
   // the variable table, the free-list memory and the result register.
   ffh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ffh_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_opcode),
      .req_var_id     (req_var_id),
      .req_src_var    (req_src_var),
      .req_alloc_size (req_alloc_size),
      .csr_we         (csr_valid && csr_ready),
      .csr_heap_size  (csr_heap_size),
      .rsp_status     (rsp_status),
      .rsp_block_addr (rsp_block_addr),
      .rsp_block_size (rsp_block_size),
      .rsp_ref_count  (rsp_ref_count)
   );

endmodule

FILE: dv/ffh_checker.sv
// Response checker for the heap manager: predicts every request and compares each response.
`timescale 1ns / 1ps

module ffh_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [3:0]  req_var_id,
   input  logic [3:0]  req_src_var,
   input  logic [15:0] req_alloc_size,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_status,
   input  logic [15:0] rsp_block_addr,
   input  logic [15:0] rsp_block_size,
   input  logic [4:0]  rsp_ref_count,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_heap_size,
   output int          fail_count
);

   localparam int MASK = (1 << ffh_pkg::ADDR_BITS) - 1;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] addr;
      logic [15:0] size;
      logic [4:0]  refs;
   } heap_rsp_type;

   logic         var_live [ffh_pkg::NUM_VARS];
   int           var_addr [ffh_pkg::NUM_VARS];
   int           var_size [ffh_pkg::NUM_VARS];
   int           var_refs [ffh_pkg::NUM_VARS];
   int           hole_addr [ffh_pkg::FREE_SLOTS];
   int           hole_size [ffh_pkg::FREE_SLOTS];
   int           hole_count;
   int           mismatches = 0;
   heap_rsp_type expected_rsps[$];

   initial fail_count = 0;

   task automatic report(input string what, input int got, input int want);
      $display("%0t ns: response %s is %0d, predicted %0d", $time, what, got, want);
      mismatches++;
   endtask

   function automatic void rebuild_holes(input int heap);
      hole_count = 0;
      if (heap > 0) begin
         hole_addr[0] = 0;
         hole_size[0] = heap;
         hole_count = 1;
      end
   endfunction

   function automatic bit insert_hole(input int a, input int sz);
      int pos;
      pos = hole_count;
      if (sz == 0) return 1;
      if (hole_count >= ffh_pkg::FREE_SLOTS) return 0;
      for (int i = 0; i < hole_count; i++) begin
         if (hole_addr[i] > a) begin
            pos = i;
            break;
         end
      end
      for (int i = hole_count; i > pos; i--) begin
         hole_addr[i] = hole_addr[i-1];
         hole_size[i] = hole_size[i-1];
      end
      hole_addr[pos] = a & MASK;
      hole_size[pos] = sz & MASK;
      hole_count++;
      return 1;
   endfunction

   function automatic void remove_hole(input int pos);
      for (int i = pos; i < hole_count - 1; i++) begin
         hole_addr[i] = hole_addr[i+1];
         hole_size[i] = hole_size[i+1];
      end
      hole_count--;
   endfunction

   function automatic void merge_holes();
      int rd, wr, ca, cs;
      rd = 0;
      wr = 0;
      while (rd < hole_count) begin
         ca = hole_addr[rd];
         cs = hole_size[rd];
         rd++;
         while (rd < hole_count && ca + cs == hole_addr[rd]) begin
            cs = cs + hole_size[rd];
            if (cs > MASK) cs = MASK;
            rd++;
         end
         hole_addr[wr] = ca;
         hole_size[wr] = cs;
         wr++;
      end
      hole_count = wr;
   endfunction

   function automatic heap_rsp_type predict_heap_op(input ffh_pkg::opcode_type op, input int v,
                                                    input int s, input int n);
      heap_rsp_type r;
      int           k, cnt, ea, es, er;
      bit           found, give;
      r = '0;
      r.status = ffh_pkg::STAT_OK;
      case (op)
         ffh_pkg::OP_ALLOC: begin
            if (var_live[v]) begin
               if (n > var_size[v]) r.status = ffh_pkg::STAT_BAD_SHRINK;
               else if (!insert_hole(var_addr[v] + n, var_size[v] - n))
                  r.status = ffh_pkg::STAT_LIST_FULL;
               else var_size[v] = n;
            end else begin
               found = 0;
               for (k = 0; k < hole_count; k++) begin
                  if (hole_size[k] >= n) begin
                     found = 1;
                     break;
                  end
               end
               if (!found) begin
                  r.status = ffh_pkg::STAT_NO_FIT;
               end else begin
                  var_live[v] = 1;
                  var_addr[v] = hole_addr[k];
                  var_size[v] = n;
                  var_refs[v] = 1;
                  hole_addr[k] = (hole_addr[k] + n) & MASK;
                  hole_size[k] = hole_size[k] - n;
                  if (hole_size[k] == 0) remove_hole(k);
               end
            end
         end
         ffh_pkg::OP_ALIAS: begin
            if (!var_live[s]) begin
               r.status = ffh_pkg::STAT_UNKNOWN;
            end else if (v != s) begin
               cnt = var_refs[s] + 1;
               if (cnt > 31) cnt = 31;
               var_refs[s] = cnt;
               var_live[v] = 1;
               var_addr[v] = var_addr[s];
               var_size[v] = var_size[s];
               var_refs[v] = cnt;
            end
         end
         ffh_pkg::OP_FREE: begin
            if (!var_live[v]) begin
               r.status = ffh_pkg::STAT_UNKNOWN;
            end else begin
               ea = var_addr[v];
               es = var_size[v];
               er = var_refs[v];
               give = er <= 1;
               if (give && es > 0 && hole_count >= ffh_pkg::FREE_SLOTS) begin
                  r.status = ffh_pkg::STAT_LIST_FULL;
               end else begin
                  var_live[v] = 0;
                  var_addr[v] = 0;
                  var_size[v] = 0;
                  var_refs[v] = 0;
                  for (int i = 0; i < ffh_pkg::NUM_VARS; i++) begin
                     if (var_live[i] && var_addr[i] == ea && var_refs[i] > 0)
                        var_refs[i]--;
                  end
                  if (give) void'(insert_hole(ea, es));
               end
            end
         end
         default: merge_holes();
      endcase
      if (var_live[v]) begin
         r.addr = 16'(var_addr[v]);
         r.size = 16'(var_size[v]);
         r.refs = 5'(var_refs[v]);
      end
      return r;
   endfunction

   always @(posedge clock) begin
      heap_rsp_type want;
      if (reset) begin
         for (int i = 0; i < ffh_pkg::NUM_VARS; i++) begin
            var_live[i] = 0;
            var_addr[i] = 0;
            var_size[i] = 0;
            var_refs[i] = 0;
         end
         rebuild_holes(int'(ffh_pkg::HEAP_RESET));
         expected_rsps.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               report("without a pending request", 1, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status) report("status", rsp_status, want.status);
               if (rsp_block_addr !== want.addr)
                  report("block_addr", rsp_block_addr, want.addr);
               if (rsp_block_size !== want.size)
                  report("block_size", rsp_block_size, want.size);
               if (rsp_ref_count !== want.refs) report("ref_count", rsp_ref_count, want.refs);
            end
         end
         if (csr_valid && csr_ready) rebuild_holes(int'(csr_heap_size));
         if (req_valid && req_ready) begin
            want = predict_heap_op(ffh_pkg::opcode_type'(req_opcode),
               int'(req_var_id), int'(req_src_var), int'(req_alloc_size));
            expected_rsps.insert(expected_rsps.size(), want);
         end
      end
      fail_count = mismatches + expected_rsps.size();
   end

endmodule

FILE: dv/tb_first_fit_heap_with_aliases.sv
// Testbench top for the heap manager: stimulus, flow control and the final verdict.
`timescale 1ns / 1ps

module tb_first_fit_heap_with_aliases;

   // Quiet cycles allowed before the run is declared hung. It lies far above the slowest
   // request and the long receiver stall, so this leaves ample margin.
   localparam int HANG_LIMIT = 5000;
   // Idle cycles after the last response before the next phase starts.
   localparam int DRAIN_CYCLES = 150;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_opcode = '0;
   logic [3:0]  req_var_id = '0;
   logic [3:0]  req_src_var = '0;
   logic [15:0] req_alloc_size = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_block_addr;
   logic [15:0] rsp_block_size;
   logic [4:0]  rsp_ref_count;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [15:0] csr_heap_size = '0;
   int          fail_count;

   int requests_sent = 0;
   int responses_seen = 0;
   int burst_left = 0;
   int stall_asks = 0;
   int stall_done = 0;
   int quiet_cycles = 0;
   int heap_now = 4096;

   always #5 clock = ~clock;

   first_fit_heap_with_aliases i_dut (.*);

   ffh_checker i_checker (.*);

   // The receiver cycles through phases of full throughput, random stalls and heavy
   // stalls. When the stimulus asks for it, it also holds off for one long stretch so
   // that the block backs up and refuses new requests.
   always @(negedge clock) begin
      int phase_left;
      int mode;
      int hold_left;
      if (reset) begin
         rsp_ready <= 0;
         phase_left = 0;
         hold_left = 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
         if (hold_left == 0) stall_done++;
      end else if (stall_asks != stall_done) begin
         hold_left = 400;
         rsp_ready <= 0;
      end else begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 120);
            mode = $urandom_range(0, 2);
         end
         phase_left--;
         case (mode)
            0: rsp_ready <= 1;
            1: rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Count responses so the stimulus knows when the block has drained.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) responses_seen++;
   end

   // Watchdog: any handshake counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
         $display("tb_first_fit_heap_with_aliases: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sends one request. Called at a falling edge and returns at a falling edge.
   // The sender works in bursts; between bursts valid drops for a random gap.
   task automatic send_request(input ffh_pkg::opcode_type op, input int v, input int s,
                               input int n);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_opcode     <= op;
      req_var_id     <= 4'(v);
      req_src_var    <= 4'(s);
      req_alloc_size <= 16'(n);
      req_valid      <= 1;
      do @(posedge clock); while (!req_ready);
      requests_sent++;
      @(negedge clock);
   endtask

   // Lowers valid and waits until every predicted response has come back.
   task automatic drain_block();
      req_valid <= 0;
      burst_left = 0;
      while (responses_seen != requests_sent) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Writes heap_size; only called while the block is idle.
   task automatic write_heap_size(input int heap);
      csr_heap_size <= 16'(heap);
      csr_valid     <= 1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 0;
      heap_now = heap;
   endtask

   // One random request. Sizes are mostly small relative to the heap so that many
   // variables fit and the free list fragments; a few sizes span the full field.
   task automatic random_request();
      int                  pick, n, lim;
      ffh_pkg::opcode_type op;
      pick = $urandom_range(0, 99);
      if (pick < 42) op = ffh_pkg::OP_ALLOC;
      else if (pick < 58) op = ffh_pkg::OP_ALIAS;
      else if (pick < 88) op = ffh_pkg::OP_FREE;
      else op = ffh_pkg::OP_COMPRESS;
      lim = heap_now / 12 + 1;
      pick = $urandom_range(0, 19);
      if (pick == 0) n = $urandom_range(0, 65535);
      else if (pick == 1) n = 0;
      else n = $urandom_range(0, lim);
      send_request(op, $urandom_range(0, 15), $urandom_range(0, 15), n);
   endtask

   initial begin
      int heaps [5];
      heaps = '{1, 65535, 200, 32768, 0};
      heaps[4] = $urandom_range(2, 65535);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // Directed part on the reset heap of 4096.
      send_request(ffh_pkg::OP_ALLOC, 0, 0, 0);        // zero-size block at the heap base
      send_request(ffh_pkg::OP_ALLOC, 1, 15, 4096);    // exact fit empties the only block
      send_request(ffh_pkg::OP_ALLOC, 2, 0, 1);        // nothing left: no fit
      send_request(ffh_pkg::OP_ALIAS, 3, 1, 0);        // alias raises the shared count
      send_request(ffh_pkg::OP_ALIAS, 3, 3, 0);        // alias onto itself changes nothing
      send_request(ffh_pkg::OP_ALIAS, 4, 5, 0);        // unknown source
      send_request(ffh_pkg::OP_ALLOC, 1, 0, 5000);     // growing a block is refused
      send_request(ffh_pkg::OP_ALLOC, 1, 0, 100);      // shrink returns the tail
      send_request(ffh_pkg::OP_ALLOC, 3, 0, 50);       // alias shrinks on its own
      send_request(ffh_pkg::OP_ALLOC, 15, 15, 65535);  // largest request: no fit
      send_request(ffh_pkg::OP_FREE, 9, 0, 0);         // unknown variable
      send_request(ffh_pkg::OP_FREE, 1, 0, 0);         // shared block: count drops
      send_request(ffh_pkg::OP_FREE, 3, 0, 0);         // last owner returns the block
      send_request(ffh_pkg::OP_COMPRESS, 0, 0, 0);     // adjacent free blocks merge
      send_request(ffh_pkg::OP_FREE, 0, 0, 0);         // zero-size block is not listed
      send_request(ffh_pkg::OP_ALLOC, 15, 15, 3000);
      for (int i = 0; i < 6; i++) send_request(ffh_pkg::OP_ALIAS, 14 - i, 15, 0);
      send_request(ffh_pkg::OP_FREE, 15, 0, 0);
      send_request(ffh_pkg::OP_COMPRESS, 15, 15, 0);
      send_request(ffh_pkg::OP_ALLOC, 5, 10, 16'hAAAA);
      drain_block();

      // Random phases, starting on the reset heap, then on each written heap size.
      for (int p = 0; p <= 5; p++) begin
         if (p > 0) write_heap_size(heaps[p-1]);
         for (int i = 0; i < 305; i++) begin
            if (p == 2 && i == 150) stall_asks++;
            random_request();
         end
         drain_block();
      end

      if (fail_count == 0) begin
         $display("tb_first_fit_heap_with_aliases: clean");
      end else begin
         $display("tb_first_fit_heap_with_aliases: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/ffh_pkg.sv
sv/ffh_ctrl.sv
sv/ffh_datapath.sv
sv/first_fit_heap_with_aliases.sv
dv/ffh_checker.sv
dv/tb_first_fit_heap_with_aliases.sv
